// ===== rtl/mgs_pkg.sv =====
`default_nettype none
package mgs_pkg;
  localparam int unsigned InW = 16;
  localparam int unsigned FracW = 14;
  localparam int unsigned OutW = 32;
  localparam int unsigned InBits = 12 * InW;
  localparam int unsigned OutBits = 4 * OutW;
  localparam logic [0:0] RegFrame = 1'b0;
  localparam logic [0:0] RegMag = 1'b1;

  // rounding to nearest, ties away from zero, of a 64-bit value by s bits
  function automatic logic signed [63:0] rnd(input logic signed [63:0] x,
                                             input int unsigned s);
    logic [63:0] mag;
    logic [63:0] half;
    half = 64'd1 << (s - 1);
    mag = x[63] ? (64'd0 - $unsigned(x)) : $unsigned(x);
    mag = (mag + half) >> s;
    rnd = x[63] ? $signed(64'd0 - mag) : $signed(mag);
  endfunction
endpackage
`default_nettype wire

// ===== rtl/madgwick_gradient_step_unit.sv =====
// madgwick gradient step unit
// slave stream s_axis_* carries one sensor request per beat: quaternion,
// normalized accelerometer and magnetometer, and the reference field.
// master stream m_axis_* returns the four-component correction quaternion,
// q17.14, saturated to 32 bits.
// apb port: reg 0 at address 0 is frame_select (0 ned, 1 enu), reg 1 at
// address 4 is use_magnetometer (reset 1). write only while the block is idle.
// the datapath is a four-stage pipeline:
//   stage 1 squares and the 16x16 cross products
//   stage 2 norm s, reference r, magnetic dot terms, q-product sums
//   stage 3 t = s + r*s, per-component coefficients and field products
//   stage 4 coefficient times q_k plus field terms, rounding, saturation
// requests pass through stages 1 to 4 on the way to tvalid. all stages advance
// together when the output is free or being taken, so one request can be taken
// every such cycle, and a stalled receiver freezes the pipe without losing data.
// reset clears the valid bits and sets the registers to their reset values.
`default_nettype none
module madgwick_gradient_step_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // fields from lsb: quat_w, quat_x, quat_y, quat_z, accel_x, accel_y, accel_z,
  // mag_x, mag_y, mag_z, ref_horizontal(15 bits), ref_vertical, one pad bit
  input  wire logic [191:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // fields from lsb: grad_w, grad_x, grad_y, grad_z
  output logic [127:0]     m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int unsigned F = mgs_pkg::FracW;

  logic frame_q, mag_q;
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= 1'b0;
      mag_q <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (paddr[2:2])
        mgs_pkg::RegFrame: frame_q <= pwdata[0];
        mgs_pkg::RegMag: mag_q <= pwdata[0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[2:2])
      mgs_pkg::RegFrame: prdata = {31'd0, frame_q};
      mgs_pkg::RegMag: prdata = {31'd0, mag_q};
      default: prdata = 32'd0;
    endcase
  end

  logic adv;
  logic [3:0] v_q;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = v_q[3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 4'd0;
    else if (adv) v_q <= {v_q[2:0], s_axis_tvalid};
  end

  // input unpack
  logic signed [15:0] q [4];
  logic signed [15:0] ax, ay, az, mx, my, mz, md, mn;
  always_comb begin
    for (int i = 0; i < 4; i++) q[i] = s_axis_tdata[16*i +: 16];
    ax = s_axis_tdata[64 +: 16];
    ay = s_axis_tdata[80 +: 16];
    az = s_axis_tdata[96 +: 16];
    mx = s_axis_tdata[112 +: 16];
    my = s_axis_tdata[128 +: 16];
    mz = s_axis_tdata[144 +: 16];
    mn = mag_q ? {1'b0, s_axis_tdata[160 +: 15]} : 16'sd0;
    md = mag_q ? s_axis_tdata[175 +: 16] : 16'sd0;
  end

  // stage 1: products
  logic signed [31:0] sq_q [4];
  logic signed [31:0] mdd_q, mnn_q;
  logic signed [31:0] pm_q [3][4]; // m{x,y,z} * q{0..3}
  logic signed [31:0] pa_q [2][4]; // a{x,y} * q{0..3}
  logic signed [31:0] xmn_q, ymn_q, zmd_q;
  logic signed [15:0] q1_q [4];
  logic signed [15:0] az1_q, md1_q, mn1_q;
  logic fr1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        sq_q[i] <= q[i] * q[i];
        pm_q[0][i] <= mx * q[i];
        pm_q[1][i] <= my * q[i];
        pm_q[2][i] <= mz * q[i];
        pa_q[0][i] <= ax * q[i];
        pa_q[1][i] <= ay * q[i];
        q1_q[i] <= q[i];
      end
      mdd_q <= md * md;
      mnn_q <= mn * mn;
      xmn_q <= mx * mn;
      ymn_q <= my * mn;
      zmd_q <= mz * md;
      az1_q <= az;
      md1_q <= md;
      mn1_q <= mn;
      fr1_q <= frame_q;
    end
  end

  // stage 2: sums, s, r, dot terms, field sums (q.2f)
  logic signed [63:0] s2_d, r2_d;
  logic signed [63:0] dot_d [4];
  logic signed [63:0] dmd_d [4], dmn_d [4], dac_d [4];
  logic signed [63:0] x, y, z, xq[4], yq[4], zq[4], aq[4], bq[4];
  always_comb begin
    x = 64'(xmn_q); y = 64'(ymn_q); z = 64'(zmd_q);
    for (int i = 0; i < 4; i++) begin
      xq[i] = 64'(pm_q[0][i]); yq[i] = 64'(pm_q[1][i]); zq[i] = 64'(pm_q[2][i]);
      aq[i] = 64'(pa_q[0][i]); bq[i] = 64'(pa_q[1][i]);
    end
    s2_d = mgs_pkg::rnd(64'sd4 * (64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2])
                        + 64'(sq_q[3])), F);
    r2_d = mgs_pkg::rnd(64'(mdd_q) + 64'(mnn_q), F);
    if (!fr1_q) begin
      dot_d[0] = mgs_pkg::rnd(-2 * (x + z), F);
      dot_d[1] = mgs_pkg::rnd(2 * (z - x), F);
      dot_d[2] = mgs_pkg::rnd(2 * (x + z), F);
      dot_d[3] = mgs_pkg::rnd(2 * (x - z), F);
      dmd_d[0] = 2 * (xq[2] - yq[1]); dmn_d[0] = 2 * (yq[3] - zq[2]);
      dac_d[0] = 2 * (bq[1] - aq[2]);
      dmd_d[1] = -2 * (xq[3] + yq[0]); dmn_d[1] = -2 * (yq[2] + zq[3]);
      dac_d[1] = 2 * (bq[0] + aq[3]);
      dmd_d[2] = 2 * (xq[0] - yq[3]); dmn_d[2] = -2 * (yq[1] + zq[0]);
      dac_d[2] = 2 * (bq[3] - aq[0]);
      dmd_d[3] = -2 * (xq[1] + yq[2]); dmn_d[3] = 2 * (yq[0] - zq[1]);
      dac_d[3] = 2 * (aq[1] + bq[2]);
    end else begin
      dot_d[0] = mgs_pkg::rnd(2 * (z - y), F);
      dot_d[1] = mgs_pkg::rnd(2 * (y - z), F);
      dot_d[2] = mgs_pkg::rnd(-2 * (y + z), F);
      dot_d[3] = mgs_pkg::rnd(2 * (y + z), F);
      dmd_d[0] = 2 * (yq[1] - xq[2]); dmn_d[0] = 2 * (zq[1] - xq[3]);
      dac_d[0] = 2 * (aq[2] - bq[1]);
      dmd_d[1] = 2 * (xq[3] + yq[0]); dmn_d[1] = 2 * (zq[0] - xq[2]);
      dac_d[1] = -2 * (bq[0] + aq[3]);
      dmd_d[2] = 2 * (yq[3] - xq[0]); dmn_d[2] = -2 * (xq[1] + zq[3]);
      dac_d[2] = 2 * (aq[0] - bq[3]);
      dmd_d[3] = 2 * (xq[1] + yq[2]); dmn_d[3] = -2 * (xq[0] + zq[2]);
      dac_d[3] = -2 * (aq[1] + bq[2]);
    end
  end

  // s reaches 2^20 when every quaternion part is -2.0
  logic signed [21:0] s2_q;
  logic signed [17:0] r2_q;
  logic signed [19:0] dot2_q [4];
  logic signed [34:0] dmd2_q [4], dmn2_q [4], dac2_q [4];
  logic signed [15:0] q2_q [4];
  logic signed [15:0] az2_q, md2_q, mn2_q;
  logic fr2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q <= s2_d[21:0];
      r2_q <= r2_d[17:0];
      for (int i = 0; i < 4; i++) begin
        dot2_q[i] <= dot_d[i][19:0];
        dmd2_q[i] <= dmd_d[i][34:0];
        dmn2_q[i] <= dmn_d[i][34:0];
        dac2_q[i] <= dac_d[i][34:0];
        q2_q[i] <= q1_q[i];
      end
      az2_q <= az1_q; md2_q <= md1_q; mn2_q <= mn1_q; fr2_q <= fr1_q;
    end
  end

  // stage 3: t and coefficients, field products
  logic signed [63:0] t3_d, c3_d [4];
  logic signed [63:0] az2x;
  logic signed [39:0] rs3;
  always_comb begin
    az2x = 2 * 64'(az2_q);
    rs3 = r2_q * s2_q;
    t3_d = 64'(s2_q) + mgs_pkg::rnd(64'(rs3), F);
    for (int i = 0; i < 4; i++) begin
      // az sign: ned +,-,-,+ ; enu -,+,+,-
      if ((i == 0 || i == 3) ^ fr2_q) c3_d[i] = t3_d + 64'(dot2_q[i]) + az2x;
      else c3_d[i] = t3_d + 64'(dot2_q[i]) - az2x;
    end
  end
  // coefficient stays below 2^24 in magnitude
  logic signed [24:0] c3_q [4];
  logic signed [50:0] fm3_q [4], fn3_q [4];
  logic signed [63:0] fa3_q [4];
  logic signed [15:0] q3_q [4];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        c3_q[i] <= c3_d[i][24:0];
        fm3_q[i] <= dmd2_q[i] * md2_q;
        fn3_q[i] <= dmn2_q[i] * mn2_q;
        fa3_q[i] <= 64'(dac2_q[i]) <<< F;
        q3_q[i] <= q2_q[i];
      end
    end
  end

  // stage 4: final sum, rounding, saturation
  logic [127:0] out_d, out_q;
  logic signed [63:0] tot, rr;
  logic signed [40:0] cq;
  always_comb begin
    out_d = '0;
    for (int i = 0; i < 4; i++) begin
      cq = c3_q[i] * q3_q[i];
      tot = (64'(cq) <<< F) + 64'(fm3_q[i]) + 64'(fn3_q[i]) + fa3_q[i];
      rr = mgs_pkg::rnd(tot, 2 * F);
      if (rr > 64'sd2147483647) out_d[32*i +: 32] = 32'h7fffffff;
      else if (rr < -64'sd2147483648) out_d[32*i +: 32] = 32'h80000000;
      else out_d[32*i +: 32] = rr[31:0];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end
  assign m_axis_tdata = out_q;
endmodule
`default_nettype wire

// ===== rtl/mgs_checker.sv =====
`default_nettype none
module mgs_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [127:0] m_axis_tdata,
  input wire logic pready
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken during stall");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
    ##1 m_axis_tready |-> ##1 m_axis_tvalid)
    else $error("result missing after latency");
  a_rdy: assert property (@(posedge clk_i) pready)
    else $error("pready low");
endmodule
bind madgwick_gradient_step_unit mgs_checker u_chk (.*);
`default_nettype wire
